FILE: rtl/dnr_pkg.sv
// shared constants, types and helpers for the decimal digit-write formatter
package dnr_pkg;

    localparam int DIGITS     = 8;
    localparam int WRITES_MAX = 8;
    localparam int MAG_W      = 32;
    localparam int POS_W      = 4;
    localparam int DEC_W      = 3;
    localparam int CODE_W     = 4;
    localparam int IDX_W      = $clog2(WRITES_MAX);
    localparam int BCD_W      = WRITES_MAX * CODE_W;
    localparam int CNT_W      = $clog2(MAG_W);

    localparam logic [CODE_W-1:0] CODE_BLANK = 4'hF;
    localparam logic [CODE_W-1:0] CODE_MINUS = 4'hA;

    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [IDX_W-1:0] last;
        logic [IDX_W-1:0] units;
        logic             dec_nz;
        logic             neg;
    } job_t;

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        if (p == '0)
            r = POS_W'(1);
        else if (p > POS_W'(DIGITS))
            r = POS_W'(DIGITS);
        else
            r = p;
        return r;
    endfunction

endpackage

FILE: rtl/decimal_number_to_digit_register_writes.sv
// top level: turns a signed decimal number into left-to-right digit-register writes
// One number is taken at a time. After a transfer in, the magnitude is converted to
// BCD one bit per cycle, then one write per window position (one to eight) leaves
// through the output register, at most one per cycle. The next number is taken once
// the last write of the current one sits in the output register. Bounds are clamped
// to 1..8 and exchanged when swapped, decimals are limited to the window width minus
// one, and position_reversed mirrors the addresses for reversed wiring.
module decimal_number_to_digit_register_writes (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_enable,
    input  logic                         cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dnr_pkg::POS_W-1:0]    first_position,
    input  logic [dnr_pkg::POS_W-1:0]    last_position,
    input  logic [dnr_pkg::MAG_W-1:0]    magnitude,
    input  logic [dnr_pkg::DEC_W-1:0]    decimals,
    input  logic                         negative,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dnr_pkg::POS_W-1:0]    digit_address,
    output logic [dnr_pkg::CODE_W-1:0]   digit_code,
    output logic                         decimal_point,
    output logic                         last_write
);
    import dnr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic             rev_reg;
    job_t             job_reg, job_next;
    logic             accept;
    logic             conv_done;
    logic             emit_done;
    logic [BCD_W-1:0] bcd;

    logic [POS_W-1:0] lo_c, hi_c, lo_s, hi_s, span;
    logic [IDX_W-1:0] last_c, dec_c;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // window and decimal saturation
    always_comb
    begin
        lo_c = clamp_pos(first_position);
        hi_c = clamp_pos(last_position);
        if (lo_c > hi_c)
        begin
            lo_s = hi_c;
            hi_s = lo_c;
        end
        else
        begin
            lo_s = lo_c;
            hi_s = hi_c;
        end
        if ((hi_s - lo_s) > POS_W'(WRITES_MAX - 1))
            lo_s = hi_s - POS_W'(WRITES_MAX - 1);
        span   = hi_s - lo_s;
        last_c = span[IDX_W-1:0];
        dec_c  = (IDX_W'(decimals) > last_c) ? last_c : IDX_W'(decimals);

        job_next.lo     = lo_s;
        job_next.last   = last_c;
        job_next.units  = last_c - dec_c;
        job_next.dec_nz = (dec_c != '0);
        job_next.neg    = negative;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (conv_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rev_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_enable)
                rev_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

    dnr_bcd_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .step      (state_reg == ST_CONV),
        .magnitude (magnitude),
        .done      (conv_done),
        .bcd       (bcd)
    );

    dnr_emit u_emit (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (conv_done),
        .enable            (state_reg == ST_EMIT),
        .job               (job_reg),
        .bcd               (bcd),
        .position_reversed (rev_reg),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .digit_address     (digit_address),
        .digit_code        (digit_code),
        .decimal_point     (decimal_point),
        .last_write        (last_write),
        .done              (emit_done)
    );

    // a transfer in always starts a conversion
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CONV)
        else $error("transfer in did not start conversion");

    // the write of the rightmost position ends the number
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_done) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after last write");

    // output register only reloads while writes are being generated
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && state_reg != ST_EMIT) |=>
        ($stable(digit_code) && $stable(digit_address) && $stable(last_write)))
        else $error("output register changed outside write sequence");

endmodule

FILE: rtl/dnr_bcd_conv.sv
// bit-serial binary to bcd converter (shift and add three), low digits only
module dnr_bcd_conv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        step,
    input  logic [dnr_pkg::MAG_W-1:0]   magnitude,
    output logic                        done,
    output logic [dnr_pkg::BCD_W-1:0]   bcd
);
    import dnr_pkg::*;

    logic [MAG_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] bcd_adj;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        for (int k = 0; k < WRITES_MAX; k++)
        begin
            if (bcd_reg[k*CODE_W +: CODE_W] >= CODE_W'(5))
                bcd_adj[k*CODE_W +: CODE_W] = bcd_reg[k*CODE_W +: CODE_W] + CODE_W'(3);
            else
                bcd_adj[k*CODE_W +: CODE_W] = bcd_reg[k*CODE_W +: CODE_W];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            bin_next = magnitude;
            bcd_next = '0;
            cnt_next = '0;
        end
        else if (step)
        begin
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[MAG_W-1]};
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = step && (cnt_reg == CNT_W'(MAG_W - 1));
    assign bcd  = bcd_reg;

endmodule

FILE: rtl/dnr_emit.sv
// digit-serial write sequencer with blanking, sign placement and output register
module dnr_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         enable,
    input  dnr_pkg::job_t                job,
    input  logic [dnr_pkg::BCD_W-1:0]    bcd,
    input  logic                         position_reversed,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [dnr_pkg::POS_W-1:0]    digit_address,
    output logic [dnr_pkg::CODE_W-1:0]   digit_code,
    output logic                         decimal_point,
    output logic                         last_write,
    output logic                         done
);
    import dnr_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              leading_reg, leading_next;
    logic              valid_reg, valid_next;
    logic [POS_W-1:0]  addr_reg, addr_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              point_reg, point_next;
    logic              lastw_reg, lastw_next;

    logic              load;
    logic [IDX_W-1:0]  j_cur, j_nxt;
    logic [CODE_W-1:0] dig_cur, dig_nxt;
    logic              blank_cur, blank_nxt;
    logic [IDX_W:0]    idx_inc;
    logic [POS_W-1:0]  pos;

    assign load    = enable && (!valid_reg || !out_stall);
    assign j_cur   = job.last - idx_reg;
    assign j_nxt   = j_cur - IDX_W'(1);
    assign dig_cur = bcd[j_cur*CODE_W +: CODE_W];
    assign dig_nxt = bcd[j_nxt*CODE_W +: CODE_W];
    assign idx_inc = {1'b0, idx_reg} + (IDX_W+1)'(1);
    assign pos     = job.lo + POS_W'(idx_reg);

    always_comb
    begin
        blank_cur = leading_reg && (idx_reg < job.units) && (dig_cur == '0);
        blank_nxt = blank_cur && (idx_inc < {1'b0, job.units}) && (dig_nxt == '0);

        if (blank_cur)
            code_next = (job.neg && !blank_nxt) ? CODE_MINUS : CODE_BLANK;
        else
            code_next = dig_cur;

        addr_next  = position_reversed ? (POS_W'(DIGITS + 1) - pos) : pos;
        point_next = job.dec_nz && (idx_reg == job.units);
        lastw_next = (idx_reg == job.last);

        idx_next     = idx_reg;
        leading_next = leading_reg;
        valid_next   = valid_reg;
        if (start)
        begin
            idx_next     = '0;
            leading_next = 1'b1;
        end
        else if (load)
        begin
            idx_next     = idx_inc[IDX_W-1:0];
            leading_next = blank_cur;
        end
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            leading_reg <= 1'b1;
            valid_reg   <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            leading_reg <= leading_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg  <= addr_next;
            code_reg  <= code_next;
            point_reg <= point_next;
            lastw_reg <= lastw_next;
        end
    end

    assign done          = load && lastw_next;
    assign out_valid     = valid_reg;
    assign digit_address = addr_reg;
    assign digit_code    = code_reg;
    assign decimal_point = point_reg;
    assign last_write    = lastw_reg;

endmodule
